FILE: rtl/core/altitude_hold_throttle_comp_core_assert.svh
// Assertion macros shared by the altitude hold checker
`ifndef ALTITUDE_HOLD_THROTTLE_COMP_CORE_ASSERT_SVH
`define ALTITUDE_HOLD_THROTTLE_COMP_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define AHTC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ahtc assertion failed");

// next-cycle implication, sampled on clk_i, off during reset
`define AHTC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ahtc assertion failed");

`endif

FILE: rtl/core/ahtc_pkg.sv
// Types, constants and register codes for the altitude hold throttle compensation
package ahtc_pkg;

  localparam int unsigned AltW       = 16;
  localparam int unsigned CompW      = 8;
  localparam int unsigned BandW      = 10;
  localparam int unsigned TransW     = 12;
  localparam int unsigned DescW      = 11;
  localparam int unsigned RGainW     = 8;
  localparam int unsigned AGainW     = 6;
  localparam int unsigned CHighW     = 7;
  localparam int unsigned RateErrW   = 11;  // holds +/- rate error limit up to 1023
  localparam int unsigned RateShift  = 8;
  localparam int unsigned AltShift   = 7;

  localparam int unsigned InDataW    = 40;
  localparam int unsigned InUserW    = 2;
  localparam int unsigned OutDataW   = 32;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 12;

  localparam int unsigned MaxRateErrorDef = 127;
  localparam int unsigned UpStepDef       = 1;

  // register indexes on the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_ALT_BAND   = 3'd0,
    REG_DESC_TRANS = 3'd1,
    REG_FAST_RATE  = 3'd2,
    REG_FINAL_RATE = 3'd3,
    REG_RATE_GAIN  = 3'd4,
    REG_ALT_GAIN   = 3'd5,
    REG_COMP_LOW   = 3'd6,
    REG_COMP_HIGH  = 3'd7
  } ahtc_reg_e;

  typedef struct packed {
    logic        [BandW-1:0]  altitude_band;
    logic        [TransW-1:0] descent_transition;
    logic signed [DescW-1:0]  fast_descent_rate;
    logic signed [DescW-1:0]  final_descent_rate;
    logic        [RGainW-1:0] rate_gain;
    logic        [AGainW-1:0] altitude_gain;
    logic signed [CompW-1:0]  comp_low;
    logic        [CHighW-1:0] comp_high;
  } ahtc_cfg_t;

  typedef struct packed {
    logic signed [AltW-1:0] altitude_cm;
    logic signed [AltW-1:0] climb_rate;
    logic                   new_sample;
    logic                   baro_valid;
    logic                   hold_mode;
    logic                   throttle_moving;
  } ahtc_item_t;

  typedef struct packed {
    logic signed [CompW-1:0] throttle_comp;
    logic                    hovering;
    logic signed [AltW-1:0]  target_altitude;
  } ahtc_result_t;

endpackage

FILE: rtl/core/ahtc_cfg.sv
// Configuration register file of the altitude hold block
module ahtc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [ahtc_pkg::CfgIdxW-1:0]  wr_index_i,
  input  logic [ahtc_pkg::CfgDataW-1:0] wr_data_i,
  output ahtc_pkg::ahtc_cfg_t           cfg_o
);

  ahtc_pkg::ahtc_cfg_t cfg_q, cfg_d;
  ahtc_pkg::ahtc_reg_e wr_reg;

  assign wr_reg = ahtc_pkg::ahtc_reg_e'(wr_index_i);

  // decode one register write
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_reg)
        ahtc_pkg::REG_ALT_BAND:   cfg_d.altitude_band      = wr_data_i[ahtc_pkg::BandW-1:0];
        ahtc_pkg::REG_DESC_TRANS: cfg_d.descent_transition = wr_data_i[ahtc_pkg::TransW-1:0];
        ahtc_pkg::REG_FAST_RATE:  cfg_d.fast_descent_rate  = $signed(wr_data_i[ahtc_pkg::DescW-1:0]);
        ahtc_pkg::REG_FINAL_RATE: cfg_d.final_descent_rate = $signed(wr_data_i[ahtc_pkg::DescW-1:0]);
        ahtc_pkg::REG_RATE_GAIN:  cfg_d.rate_gain          = wr_data_i[ahtc_pkg::RGainW-1:0];
        ahtc_pkg::REG_ALT_GAIN:   cfg_d.altitude_gain      = wr_data_i[ahtc_pkg::AGainW-1:0];
        ahtc_pkg::REG_COMP_LOW:   cfg_d.comp_low           = $signed(wr_data_i[ahtc_pkg::CompW-1:0]);
        ahtc_pkg::REG_COMP_HIGH:  cfg_d.comp_high          = wr_data_i[ahtc_pkg::CHighW-1:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.altitude_band      <= 10'd150;
      cfg_q.descent_transition <= 12'd1000;
      cfg_q.fast_descent_rate  <= -11'sd100;
      cfg_q.final_descent_rate <= -11'sd50;
      cfg_q.rate_gain          <= 8'd32;
      cfg_q.altitude_gain      <= 6'd16;
      cfg_q.comp_low           <= -8'sd10;
      cfg_q.comp_high          <= 7'd30;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/ahtc_law.sv
// Control law: altitude/rate regulation, clamp, slew and the stored state
module ahtc_law #(
  parameter int unsigned MaxRateError = ahtc_pkg::MaxRateErrorDef,
  parameter int unsigned UpStep       = ahtc_pkg::UpStepDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,   // request in the input stage is processed
  input  ahtc_pkg::ahtc_item_t    item_i,
  input  ahtc_pkg::ahtc_cfg_t     cfg_i,
  output ahtc_pkg::ahtc_result_t  result_o  // values after this request's update
);

  localparam logic signed [ahtc_pkg::RateErrW-1:0] RateLim =
    ahtc_pkg::RateErrW'(MaxRateError);
  localparam logic signed [ahtc_pkg::CompW:0] UpInc = (ahtc_pkg::CompW + 1)'(UpStep);

  logic signed [ahtc_pkg::CompW-1:0] comp_q, comp_d;
  logic signed [ahtc_pkg::AltW-1:0]  target_q, target_d;

  logic signed [16:0] alt_err;
  logic signed [16:0] band_s17, trans_s17;
  logic               above_band;
  logic signed [10:0] want_rate;
  logic signed [16:0] rate_diff, rate_lim17;
  logic signed [10:0] rate_err;
  logic signed [19:0] rate_prod, rate_shift;
  logic signed [10:0] pos_err;
  logic signed [17:0] pos_prod, pos_shift;
  logic signed [11:0] corr, corr_c1, corr_c2, lo12, hi12, comp12;
  logic signed [8:0]  comp_up, comp_dn;
  logic               regulate, hovering;

  // altitude error against the stored target
  assign alt_err    = {item_i.altitude_cm[15], item_i.altitude_cm} - {target_q[15], target_q};
  assign band_s17   = $signed({7'b0, cfg_i.altitude_band});
  assign trans_s17  = $signed({5'b0, cfg_i.descent_transition});
  assign above_band = alt_err > band_s17;

  // rate branch: clamped climb rate error times gain, >>> 8
  assign want_rate  = (alt_err > trans_s17) ? cfg_i.fast_descent_rate : cfg_i.final_descent_rate;
  assign rate_diff  = {item_i.climb_rate[15], item_i.climb_rate}
                    - {{6{want_rate[10]}}, want_rate};
  assign rate_lim17 = {{6{RateLim[10]}}, RateLim};

  always_comb begin
    if (rate_diff > rate_lim17)       rate_err = RateLim;
    else if (rate_diff < -rate_lim17) rate_err = -RateLim;
    else                              rate_err = rate_diff[10:0];
  end

  assign rate_prod  = rate_err * $signed({1'b0, cfg_i.rate_gain});
  assign rate_shift = rate_prod >>> ahtc_pkg::RateShift;

  // position branch: error clamped to the band times gain, >>> 7
  always_comb begin
    if (alt_err > band_s17)       pos_err = $signed({1'b0, cfg_i.altitude_band});
    else if (alt_err < -band_s17) pos_err = -$signed({1'b0, cfg_i.altitude_band});
    else                          pos_err = alt_err[10:0];
  end

  assign pos_prod  = pos_err * $signed({1'b0, cfg_i.altitude_gain});
  assign pos_shift = pos_prod >>> ahtc_pkg::AltShift;

  // negated correction, then clamp; low limit wins when limits cross
  assign corr   = above_band ? -rate_shift[11:0] : -pos_shift[11:0];
  assign lo12   = {{4{cfg_i.comp_low[7]}}, cfg_i.comp_low};
  assign hi12   = $signed({5'b0, cfg_i.comp_high});
  assign comp12 = {{4{comp_q[7]}}, comp_q};

  always_comb begin
    if (corr < lo12)      corr_c1 = lo12;
    else if (corr > hi12) corr_c1 = hi12;
    else                  corr_c1 = corr;
    corr_c2 = (corr_c1 < lo12) ? lo12 : corr_c1;
  end

  assign comp_up = {comp_q[7], comp_q} + UpInc;
  assign comp_dn = {comp_q[7], comp_q} - 9'sd1;

  // mode selection and state update
  assign hovering = !item_i.hold_mode && !item_i.throttle_moving;
  assign regulate = (item_i.hold_mode || !item_i.throttle_moving)
                 && item_i.new_sample && item_i.baro_valid;

  always_comb begin
    comp_d   = comp_q;
    target_d = target_q;
    if (regulate) begin
      if (corr_c2 > comp12) begin
        comp_d = (comp_up > 9'sd127) ? 8'sd127 : comp_up[7:0];
      end else if (corr_c2 < comp12) begin
        comp_d = (comp_dn < -9'sd128) ? -8'sd128 : comp_dn[7:0];
      end
    end else if (!item_i.hold_mode && item_i.throttle_moving) begin
      target_d = item_i.altitude_cm;
      if (comp_q > 8'sd0)      comp_d = comp_q - 8'sd1;
      else if (comp_q < 8'sd0) comp_d = comp_q + 8'sd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_q   <= '0;
      target_q <= '0;
    end else if (step_i) begin
      comp_q   <= comp_d;
      target_q <= target_d;
    end
  end

  assign result_o.throttle_comp   = comp_d;
  assign result_o.hovering        = hovering;
  assign result_o.target_altitude = target_d;

endmodule

FILE: rtl/core/altitude_hold_throttle_comp_core.sv
// Altitude hold throttle compensation: one control tick per request, pipelined at one
// request per clock while the result stream does not stall. An accepted request sits in
// the input register; its result is loaded into the output register when that register
// is free, and in the same step the stored compensation and target altitude are updated.
// The output register lets a new request be taken while a finished result waits.
// Configuration writes are always ready and take effect from the next cycle.
module altitude_hold_throttle_comp_core #(
  parameter int unsigned MaxRateError = ahtc_pkg::MaxRateErrorDef,
  parameter int unsigned UpStep       = ahtc_pkg::UpStepDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [15:0] altitude_cm, [31:16] climb_rate, [32] hold_mode, [33] throttle_moving
  input  logic [ahtc_pkg::InDataW-1:0]  s_axis_tdata,
  // [0] new_sample, [1] baro_valid
  input  logic [ahtc_pkg::InUserW-1:0]  s_axis_tuser,
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] throttle_comp, [8] hovering, [24:9] target_altitude
  output logic [ahtc_pkg::OutDataW-1:0] m_axis_tdata,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ahtc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ahtc_pkg::CfgDataW-1:0] cfg_data_i
);

  ahtc_pkg::ahtc_cfg_t    cfg;
  ahtc_pkg::ahtc_item_t   item_q, item_d;
  ahtc_pkg::ahtc_result_t result_d, result_q;
  logic                   in_valid_q, in_valid_d;
  logic                   out_valid_q, out_valid_d;
  logic                   out_free, advance, in_accept;

  assign cfg_ready_o = 1'b1;

  ahtc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // stage handshake
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // unpack the incoming request
  always_comb begin
    item_d.altitude_cm     = $signed(s_axis_tdata[15:0]);
    item_d.climb_rate      = $signed(s_axis_tdata[31:16]);
    item_d.hold_mode       = s_axis_tdata[32];
    item_d.throttle_moving = s_axis_tdata[33];
    item_d.new_sample      = s_axis_tuser[0];
    item_d.baro_valid      = s_axis_tuser[1];
  end

  ahtc_law #(
    .MaxRateError (MaxRateError),
    .UpStep       (UpStep)
  ) u_law (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result_d)
  );

  // valid flags of the input and output stages
  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept)    in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (advance)            out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) item_q <= item_d;
    if (advance)   result_q <= result_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, result_q.target_altitude, result_q.hovering,
                          result_q.throttle_comp};

endmodule

FILE: rtl/core/ahtc_checker.sv
// Port-level checker for the altitude hold block, bound to the top level
`include "altitude_hold_throttle_comp_core_assert.svh"

module ahtc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [ahtc_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o
);

  // config port never stalls
  `AHTC_ASSERT_IMPL(cfg_always_ready_a, cfg_valid_i, cfg_ready_o)

  // empty output register means a request can always be taken
  `AHTC_ASSERT_IMPL(ready_when_out_empty_a, !m_axis_tvalid, s_axis_tready)

  // a stalled result holds its value
  `AHTC_ASSERT_NEXT(out_hold_a, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // no result right after reset release
  `AHTC_ASSERT_IMPL(no_result_after_reset_a, $rose(rst_ni), !m_axis_tvalid)

endmodule

bind altitude_hold_throttle_comp_core ahtc_checker u_ahtc_checker (.*);

FILE: tb/altitude_hold_throttle_comp_core_tb.sv
// Self-checking testbench for the altitude hold throttle compensation core
module altitude_hold_throttle_comp_core_tb;

  localparam int WatchdogLimit = 2000;
  localparam int HoldOffCycles = 300;
  localparam int SettleCycles  = 4;
  localparam int PhaseItems    = 70;

  // Predicts compensation, hover flag and target for each request, then checks results
  class throttle_comp_scoreboard;
    ahtc_pkg::ahtc_cfg_t                cfg;
    logic signed [ahtc_pkg::CompW-1:0]  comp_q;
    logic signed [ahtc_pkg::AltW-1:0]   target_q;
    ahtc_pkg::ahtc_result_t             expected_q[$];
    int                                 mismatches;

    function new();
      cfg.altitude_band      = 10'd150;
      cfg.descent_transition = 12'd1000;
      cfg.fast_descent_rate  = -11'sd100;
      cfg.final_descent_rate = -11'sd50;
      cfg.rate_gain          = 8'd32;
      cfg.altitude_gain      = 6'd16;
      cfg.comp_low           = -8'sd10;
      cfg.comp_high          = 7'd30;
      comp_q     = '0;
      target_q   = '0;
      mismatches = 0;
    endfunction

    function int clip(int x, int lo, int hi);
      if (x < lo) return lo;
      if (x > hi) return hi;
      return x;
    endfunction

    function void write_reg(ahtc_pkg::ahtc_reg_e idx, logic [ahtc_pkg::CfgDataW-1:0] data);
      case (idx)
        ahtc_pkg::REG_ALT_BAND:   cfg.altitude_band      = data[ahtc_pkg::BandW-1:0];
        ahtc_pkg::REG_DESC_TRANS: cfg.descent_transition = data[ahtc_pkg::TransW-1:0];
        ahtc_pkg::REG_FAST_RATE:  cfg.fast_descent_rate  = data[ahtc_pkg::DescW-1:0];
        ahtc_pkg::REG_FINAL_RATE: cfg.final_descent_rate = data[ahtc_pkg::DescW-1:0];
        ahtc_pkg::REG_RATE_GAIN:  cfg.rate_gain          = data[ahtc_pkg::RGainW-1:0];
        ahtc_pkg::REG_ALT_GAIN:   cfg.altitude_gain      = data[ahtc_pkg::AGainW-1:0];
        ahtc_pkg::REG_COMP_LOW:   cfg.comp_low           = data[ahtc_pkg::CompW-1:0];
        ahtc_pkg::REG_COMP_HIGH:  cfg.comp_high          = data[ahtc_pkg::CHighW-1:0];
        default: ;
      endcase
    endfunction

    // One regulation step on a fresh, valid sample
    function void slew_comp(int alt, int roc);
      int band, err, want, rate_err, pos_err, corr, comp, lo, hi, lim;
      band = int'(cfg.altitude_band);
      lo   = int'($signed(cfg.comp_low));
      hi   = int'(cfg.comp_high);
      lim  = int'(ahtc_pkg::MaxRateErrorDef);
      err  = alt - int'($signed(target_q));
      if (err > band) begin
        want = (err > int'(cfg.descent_transition)) ? int'($signed(cfg.fast_descent_rate))
                                                     : int'($signed(cfg.final_descent_rate));
        rate_err = clip(roc - want, -lim, lim);
        corr = -((rate_err * int'(cfg.rate_gain)) >>> ahtc_pkg::RateShift);
      end else begin
        pos_err = clip(err, -band, band);
        corr = -((pos_err * int'(cfg.altitude_gain)) >>> ahtc_pkg::AltShift);
      end
      corr = clip(corr, lo, hi);
      if (corr < lo) corr = lo;
      comp = int'(comp_q);
      if (corr > comp) begin
        comp = comp + int'(ahtc_pkg::UpStepDef);
        if (comp > 127) comp = 127;
      end else if (corr < comp) begin
        comp = comp - 1;
        if (comp < -128) comp = -128;
      end
      comp_q = comp[ahtc_pkg::CompW-1:0];
    endfunction

    function void note_request(ahtc_pkg::ahtc_item_t it);
      ahtc_pkg::ahtc_result_t res;
      logic                   hover;
      logic                   fresh;
      fresh = it.new_sample && it.baro_valid;
      if (it.hold_mode) begin
        hover = 1'b0;
        if (fresh) slew_comp(int'($signed(it.altitude_cm)), int'($signed(it.climb_rate)));
      end else if (!it.throttle_moving) begin
        hover = 1'b1;
        if (fresh) slew_comp(int'($signed(it.altitude_cm)), int'($signed(it.climb_rate)));
      end else begin
        // stick moving: target tracks altitude, comp decays toward zero
        hover    = 1'b0;
        target_q = it.altitude_cm;
        if (comp_q > 0) comp_q = comp_q - 1;
        else if (comp_q < 0) comp_q = comp_q + 1;
      end
      res.throttle_comp   = comp_q;
      res.hovering        = hover;
      res.target_altitude = target_q;
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [ahtc_pkg::OutDataW-1:0] data);
      ahtc_pkg::ahtc_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h with no request pending", data);
        return;
      end
      want = expected_q.pop_front();
      if (data[7:0] !== want.throttle_comp || data[8] !== want.hovering ||
          data[24:9] !== want.target_altitude) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: comp exp %0d got %0d, hover exp %0b got %0b, target exp %0d got %0d",
                   want.throttle_comp, $signed(data[7:0]), want.hovering, data[8],
                   want.target_altitude, $signed(data[24:9]));
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [ahtc_pkg::InDataW-1:0]   s_axis_tdata;
  logic [ahtc_pkg::InUserW-1:0]   s_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [ahtc_pkg::OutDataW-1:0]  m_axis_tdata;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [ahtc_pkg::CfgIdxW-1:0]   cfg_index_i;
  logic [ahtc_pkg::CfgDataW-1:0]  cfg_data_i;

  throttle_comp_scoreboard sb;
  ahtc_pkg::ahtc_cfg_t     cur_cfg;
  int                      anchor_alt;
  int                      idle_cycles;
  int                      n_requests;
  int                      n_results;
  int                      n_cfg_writes;
  bit                      steady;
  bit                      hold_off_req;

  altitude_hold_throttle_comp_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Mostly short gaps, a few long ones; none in steady stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Handshake monitor: feeds the scoreboard and the watchdog
  always @(posedge clk_i) begin
    ahtc_pkg::ahtc_item_t seen;
    bit                   busy;
    busy = 1'b0;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        sb.write_reg(ahtc_pkg::ahtc_reg_e'(cfg_index_i), cfg_data_i);
        n_cfg_writes++;
        busy = 1'b1;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        seen.altitude_cm     = s_axis_tdata[15:0];
        seen.climb_rate      = s_axis_tdata[31:16];
        seen.hold_mode       = s_axis_tdata[32];
        seen.throttle_moving = s_axis_tdata[33];
        seen.new_sample      = s_axis_tuser[0];
        seen.baro_valid      = s_axis_tuser[1];
        sb.note_request(seen);
        n_requests++;
        busy = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata);
        n_results++;
        busy = 1'b1;
      end
    end
    idle_cycles = busy ? 0 : idle_cycles + 1;
  end

  // Watchdog
  initial begin
    wait (idle_cycles >= WatchdogLimit);
    $display("watchdog: no handshake for %0d cycles", WatchdogLimit);
    $display("CHECKS FAILED");
    $finish;
  end

  // Result receiver with random back-pressure and one long hold-off on request
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        stall = pick_gap();
        if (stall == 0) begin
          m_axis_tready <= 1'b1;
          @(posedge clk_i);
        end else begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
    end
  end

  // Offer one request, wait for acceptance, then idle for a random gap
  task automatic send_item(input ahtc_pkg::ahtc_item_t it);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(ahtc_pkg::InDataW-34){1'b0}}, it.throttle_moving, it.hold_mode,
                      it.climb_rate, it.altitude_cm};
    s_axis_tuser  <= {it.baro_valid, it.new_sample};
    do @(posedge clk_i); while (!s_axis_tready);
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic sender_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic put_reg(input ahtc_pkg::ahtc_reg_e idx,
                         input logic [ahtc_pkg::CfgDataW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Write every register; only called while the block is idle
  task automatic program_settings(input ahtc_pkg::ahtc_cfg_t c);
    put_reg(ahtc_pkg::REG_ALT_BAND,   ahtc_pkg::CfgDataW'(c.altitude_band));
    put_reg(ahtc_pkg::REG_DESC_TRANS, ahtc_pkg::CfgDataW'(c.descent_transition));
    put_reg(ahtc_pkg::REG_FAST_RATE,  ahtc_pkg::CfgDataW'(c.fast_descent_rate));
    put_reg(ahtc_pkg::REG_FINAL_RATE, ahtc_pkg::CfgDataW'(c.final_descent_rate));
    put_reg(ahtc_pkg::REG_RATE_GAIN,  ahtc_pkg::CfgDataW'(c.rate_gain));
    put_reg(ahtc_pkg::REG_ALT_GAIN,   ahtc_pkg::CfgDataW'(c.altitude_gain));
    put_reg(ahtc_pkg::REG_COMP_LOW,   ahtc_pkg::CfgDataW'(c.comp_low));
    put_reg(ahtc_pkg::REG_COMP_HIGH,  ahtc_pkg::CfgDataW'(c.comp_high));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    cur_cfg = c;
  endtask

  function automatic ahtc_pkg::ahtc_item_t mk(int alt, int roc, bit ns, bit bv, bit hold,
                                              bit mov);
    ahtc_pkg::ahtc_item_t it;
    it.altitude_cm     = alt[ahtc_pkg::AltW-1:0];
    it.climb_rate      = roc[ahtc_pkg::AltW-1:0];
    it.new_sample      = ns;
    it.baro_valid      = bv;
    it.hold_mode       = hold;
    it.throttle_moving = mov;
    return it;
  endfunction

  // Mostly hold/hover samples around the anchor altitude, with some stick-moving tracking requests
  task automatic make_item(output ahtc_pkg::ahtc_item_t it);
    int r, spread, alt_i, roc_i;
    r = $urandom_range(0, 99);
    it.new_sample = ($urandom_range(0, 9) != 0);
    it.baro_valid = ($urandom_range(0, 9) != 0);
    if (r < 12) begin
      it.hold_mode       = 1'b0;
      it.throttle_moving = 1'b1;
    end else if (r < 40) begin
      it.hold_mode       = 1'b1;
      it.throttle_moving = $urandom_range(0, 1);
    end else begin
      it.hold_mode       = 1'b0;
      it.throttle_moving = 1'b0;
    end
    r = $urandom_range(0, 9);
    if (r < 4) spread = int'(cur_cfg.altitude_band) + 20;
    else if (r < 7) spread = int'(cur_cfg.descent_transition) + 300;
    else spread = 3000;
    alt_i = anchor_alt + int'($urandom_range(0, 2 * spread)) - spread;
    alt_i = sb.clip(alt_i, -32768, 32767);
    if ($urandom_range(0, 9) == 0) alt_i = int'($signed(16'($urandom())));
    roc_i = int'($urandom_range(0, 600)) - 300;
    if ($urandom_range(0, 6) == 0) roc_i = int'($signed(16'($urandom())));
    it.altitude_cm = alt_i[ahtc_pkg::AltW-1:0];
    it.climb_rate  = roc_i[ahtc_pkg::AltW-1:0];
    if (!it.hold_mode && it.throttle_moving) anchor_alt = alt_i;
  endtask

  task automatic run_burst(input int count, input bit pause_mid);
    ahtc_pkg::ahtc_item_t it;
    for (int k = 0; k < count; k++) begin
      if (pause_mid && k == count / 2) begin
        sender_idle();
        wait_drained();
      end
      make_item(it);
      send_item(it);
    end
    sender_idle();
  endtask

  // Band edges, descent transition, flag combinations and field extremes
  task automatic run_directed();
    send_item(mk(0, 0, 0, 0, 0, 1));
    send_item(mk(150, 0, 1, 1, 0, 0));
    send_item(mk(151, -32768, 1, 1, 0, 0));
    send_item(mk(1000, 32767, 1, 1, 1, 0));
    send_item(mk(1001, 0, 1, 1, 1, 0));
    send_item(mk(-150, 0, 1, 1, 0, 0));
    send_item(mk(-151, 0, 1, 1, 0, 0));
    send_item(mk(-32768, 0, 1, 1, 1, 0));
    send_item(mk(32767, 32767, 1, 1, 0, 0));
    send_item(mk(500, 0, 1, 0, 1, 0));
    send_item(mk(500, 0, 0, 1, 0, 0));
    send_item(mk(500, 0, 0, 0, 0, 0));
    send_item(mk(-32768, -1, 0, 1, 0, 1));
    send_item(mk(32767, -32768, 1, 1, 0, 0));
    send_item(mk(32767, 0, 1, 1, 1, 1));
    send_item(mk(32767, 100, 0, 0, 0, 1));
    send_item(mk(-32768, -500, 1, 1, 1, 0));
    send_item(mk(-1, -1, 1, 1, 0, 0));
    send_item(mk(100, 5, 1, 1, 0, 1));
    send_item(mk(100, 5, 1, 1, 0, 1));
    send_item(mk(40, -40, 1, 1, 1, 1));
    send_item(mk(0, 0, 1, 1, 0, 1));
    sender_idle();
    anchor_alt = 0;
  endtask

  function automatic ahtc_pkg::ahtc_cfg_t random_cfg();
    ahtc_pkg::ahtc_cfg_t c;
    c.altitude_band      = $urandom_range(0, 1023);
    c.descent_transition = $urandom_range(0, 4095);
    c.fast_descent_rate  = ahtc_pkg::DescW'(-int'($urandom_range(0, 1023)));
    c.final_descent_rate = ahtc_pkg::DescW'(-int'($urandom_range(0, 1023)));
    c.rate_gain          = $urandom_range(0, 255);
    c.altitude_gain      = $urandom_range(0, 32);
    c.comp_low           = ahtc_pkg::CompW'(-int'($urandom_range(0, 128)));
    c.comp_high          = $urandom_range(0, 127);
    return c;
  endfunction

  // Main sequence
  initial begin
    ahtc_pkg::ahtc_cfg_t c;
    sb            = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = ahtc_pkg::REG_ALT_BAND;
    cfg_data_i    = '0;
    steady        = 1'b0;
    hold_off_req  = 1'b0;
    idle_cycles   = 0;
    n_requests    = 0;
    n_results     = 0;
    n_cfg_writes  = 0;
    anchor_alt    = 0;
    cur_cfg       = sb.cfg;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values first
    run_directed();
    wait_drained();

    for (int phase = 0; phase < 7; phase++) begin
      c = random_cfg();
      case (phase)
        0: begin
          c.altitude_band = 10'd1023; c.descent_transition = 12'd4095;
          c.fast_descent_rate = -11'sd1023; c.final_descent_rate = -11'sd1023;
          c.rate_gain = 8'd255; c.altitude_gain = 6'd32;
          c.comp_low = -8'sd128; c.comp_high = 7'd127;
        end
        1: c = '0;
        5: begin
          c.altitude_band = 10'd0; c.descent_transition = 12'd4095;
          c.fast_descent_rate = -11'sd1023; c.final_descent_rate = 11'sd0;
          c.rate_gain = 8'd255; c.altitude_gain = 6'd32;
          c.comp_low = -8'sd128; c.comp_high = 7'd0;
        end
        default: ;
      endcase
      program_settings(c);
      steady = (phase == 2);
      if (phase == 3) hold_off_req = 1'b1;
      run_burst(PhaseItems, phase == 4);
      steady = 1'b0;
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    $display("Covered %0d requests and %0d results under 8 register settings (%0d writes),",
             n_requests, n_results, n_cfg_writes);
    $display("with band edges, both descent rates, hover/track/forced hold and back-pressure.");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
